// ===== sv/sita_pkg.sv =====
// Shared types and constants for the signed integer to decimal ASCII converter.
// No dependencies.
package sita_pkg;

  localparam int unsigned VALUE_W = 32;
  localparam int unsigned BCNT_W  = 5;
  localparam int unsigned CHAR_W  = 8;

  localparam logic [CHAR_W-1:0] CH_ZERO  = 8'd48;
  localparam logic [CHAR_W-1:0] CH_MINUS = 8'd45;

  localparam logic [BCNT_W-1:0] BCNT_LAST = 5'd31;

  // Controller to datapath commands
  typedef struct packed {
    logic load;
    logic dabble;
    logic skip;
    logic emit_sign;
    logic emit_digit;
  } sita_cmd_t;

  // Datapath to controller status
  typedef struct packed {
    logic conv_done;
    logic lead_zero;
    logic neg;
    logic last_digit;
  } sita_stat_t;

endpackage

// ===== sv/signed_int_to_decimal_ascii.sv =====
// Signed 32-bit integer to decimal ASCII text, most significant character first.
// Sequence: 1 load, 32 shift-add-3 steps and the leading zero skip checks, then one char
// per cycle ('-' then digits).
// Throughput: one request at a time; busy drops in the cycle the last character is out.
// Reset: rst_ni asynchronous, active low, returns to idle with no strobe pending.
// The receiver cannot stall: each character strobe lasts exactly one cycle.
module signed_int_to_decimal_ascii import sita_pkg::*; #(
  parameter int unsigned MAX_DIGITS = 10   // decimal positions held, 1..20
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                start,
  output logic                busy,
  input  logic [VALUE_W-1:0]  value_i,
  output logic                char_valid_o,
  output logic [CHAR_W-1:0]   char_code_o,
  output logic                last_char_o
);

  // Command and status between the sequencer and the datapath
  sita_cmd_t  cmd;
  sita_stat_t stat;

  // Sequencer: idle -> convert (32 steps) -> skip leading zeros -> sign (if negative) -> digits
  sita_ctrl u_ctrl (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .start_i(start),
    .stat_i (stat),
    .cmd_o  (cmd),
    .busy_o (busy)
  );

  // Datapath: magnitude, BCD register of MAX_DIGITS digits, registered character output.
  // When the magnitude needs more than MAX_DIGITS digits, only the low digits are kept
  // and all MAX_DIGITS of them are emitted.
  sita_dp #(
    .MAX_DIGITS(MAX_DIGITS)
  ) u_dp (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .value_i     (value_i),
    .cmd_i       (cmd),
    .stat_o      (stat),
    .char_valid_o(char_valid_o),
    .char_code_o (char_code_o),
    .last_char_o (last_char_o)
  );

endmodule

// ===== sv/sita_dp.sv =====
// Datapath: sign/magnitude split, shift-add-3 BCD conversion, character output register.
// Depends on sita_pkg.
module sita_dp import sita_pkg::*; #(
  parameter int unsigned MAX_DIGITS = 10
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic [VALUE_W-1:0]  value_i,
  input  sita_cmd_t           cmd_i,
  output sita_stat_t          stat_o,
  output logic                char_valid_o,
  output logic [CHAR_W-1:0]   char_code_o,
  output logic                last_char_o
);

  localparam int unsigned BCD_W  = 4 * MAX_DIGITS;
  localparam int unsigned DCNT_W = $clog2(MAX_DIGITS + 1);

  logic [VALUE_W-1:0] bin_q, bin_d;
  logic [BCD_W-1:0]   bcd_q, bcd_d;
  logic [BCD_W-1:0]   bcd_adj;
  logic               ovf_q, ovf_d;
  logic               neg_q, neg_d;
  logic [BCNT_W-1:0]  bcnt_q, bcnt_d;
  logic [DCNT_W-1:0]  dcnt_q, dcnt_d;
  logic               valid_q, valid_d;
  logic [CHAR_W-1:0]  code_q, code_d;
  logic               last_q, last_d;
  logic [3:0]         top_digit;

  assign top_digit = bcd_q[BCD_W-1 -: 4];

  // add 3 to every digit of 5 or more before the shift
  always_comb begin
    for (int i = 0; i < MAX_DIGITS; i++) begin
      if (bcd_q[i*4 +: 4] >= 4'd5) begin
        bcd_adj[i*4 +: 4] = bcd_q[i*4 +: 4] + 4'd3;
      end else begin
        bcd_adj[i*4 +: 4] = bcd_q[i*4 +: 4];
      end
    end
  end

  always_comb begin
    bin_d   = bin_q;
    bcd_d   = bcd_q;
    ovf_d   = ovf_q;
    neg_d   = neg_q;
    bcnt_d  = bcnt_q;
    dcnt_d  = dcnt_q;
    valid_d = 1'b0;
    code_d  = code_q;
    last_d  = last_q;
    if (cmd_i.load) begin
      neg_d  = value_i[VALUE_W-1];
      bin_d  = value_i[VALUE_W-1] ? (VALUE_W'(0) - value_i) : value_i;
      bcd_d  = '0;
      ovf_d  = 1'b0;
      bcnt_d = '0;
      dcnt_d = DCNT_W'(MAX_DIGITS);
    end
    if (cmd_i.dabble) begin
      bcd_d  = {bcd_adj[BCD_W-2:0], bin_q[VALUE_W-1]};
      ovf_d  = ovf_q | bcd_adj[BCD_W-1];  // digit dropped above the top position
      bin_d  = {bin_q[VALUE_W-2:0], 1'b0};
      bcnt_d = bcnt_q + BCNT_W'(1);
    end
    if (cmd_i.skip || cmd_i.emit_digit) begin
      bcd_d  = bcd_q << 4;
      dcnt_d = dcnt_q - DCNT_W'(1);
    end
    if (cmd_i.emit_sign) begin
      valid_d = 1'b1;
      code_d  = CH_MINUS;
      last_d  = 1'b0;
    end
    if (cmd_i.emit_digit) begin
      valid_d = 1'b1;
      code_d  = CH_ZERO + CHAR_W'(top_digit);
      last_d  = (dcnt_q == DCNT_W'(1));
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
      bcnt_q  <= '0;
      dcnt_q  <= '0;
    end else begin
      valid_q <= valid_d;
      bcnt_q  <= bcnt_d;
      dcnt_q  <= dcnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    bin_q  <= bin_d;
    bcd_q  <= bcd_d;
    ovf_q  <= ovf_d;
    neg_q  <= neg_d;
    code_q <= code_d;
    last_q <= last_d;
  end

  assign stat_o.conv_done  = (bcnt_q == BCNT_LAST);
  assign stat_o.lead_zero  = !ovf_q && (top_digit == 4'd0) && (dcnt_q > DCNT_W'(1));
  assign stat_o.neg        = neg_q;
  assign stat_o.last_digit = (dcnt_q == DCNT_W'(1));

  assign char_valid_o = valid_q;
  assign char_code_o  = code_q;
  assign last_char_o  = last_q;

  a_char_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    valid_q |-> (code_q == CH_MINUS) ||
                ((code_q >= CH_ZERO) && (code_q <= CH_ZERO + 8'd9)))
    else $error("output character outside '-' and digits");

  a_sign_not_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (valid_q && code_q == CH_MINUS) |-> !last_q)
    else $error("minus sign flagged as last character");

  a_gap_after_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (valid_q && last_q) |=> !valid_q)
    else $error("character strobe right after last character");

  a_digit_count: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.emit_digit |-> (dcnt_q != '0))
    else $error("digit emitted with no digit positions left");

endmodule

// ===== sv/sita_ctrl.sv =====
// Controller state machine: sequences load, conversion, zero skip and character emission.
// Depends on sita_pkg.
module sita_ctrl import sita_pkg::*; (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       start_i,
  input  sita_stat_t stat_i,
  output sita_cmd_t  cmd_o,
  output logic       busy_o
);

  typedef enum logic [4:0] {
    ST_IDLE = 5'b00001,
    ST_CONV = 5'b00010,
    ST_SKIP = 5'b00100,
    ST_SIGN = 5'b01000,
    ST_EMIT = 5'b10000
  } state_e;

  state_e state_q, state_d;

  always_comb begin
    state_d = state_q;
    cmd_o   = '0;
    unique case (state_q)
      ST_IDLE: begin
        if (start_i) begin
          cmd_o.load = 1'b1;
          state_d    = ST_CONV;
        end
      end
      ST_CONV: begin
        cmd_o.dabble = 1'b1;
        if (stat_i.conv_done) begin
          state_d = ST_SKIP;
        end
      end
      ST_SKIP: begin
        if (stat_i.lead_zero) begin
          cmd_o.skip = 1'b1;
        end else if (stat_i.neg) begin
          state_d = ST_SIGN;
        end else begin
          state_d = ST_EMIT;
        end
      end
      ST_SIGN: begin
        cmd_o.emit_sign = 1'b1;
        state_d         = ST_EMIT;
      end
      ST_EMIT: begin
        cmd_o.emit_digit = 1'b1;
        if (stat_i.last_digit) begin
          state_d = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  assign busy_o = (state_q != ST_IDLE);

  a_load_idle_only: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_o.load |=> (state_q == ST_CONV))
    else $error("load did not start conversion");

  a_sign_then_digit: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_SIGN) |=> (state_q == ST_EMIT))
    else $error("minus sign not followed by digits");

  a_conv_exit: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_SKIP) |-> $past(state_q == ST_CONV || state_q == ST_SKIP))
    else $error("zero skip entered without conversion");

endmodule
